// ----- rtl/mrfc_pkg.sv -----
// Shared types, codes and constants for the mapped region fault checker.
package mrfc_pkg;

    localparam int REGION_COUNT_DEF       = 16;
    localparam int ADDRESS_LIMIT_BITS_DEF = 38;
    localparam int PAGE_BYTES             = 4096;
    localparam int PAGE_SHIFT             = 12;
    localparam int READ_BYTES_W           = 13;

    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 104;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FAULT = 1'b1;

    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_STORE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_REGION = 2'd1;
    localparam logic [1:0] ST_REFUSED   = 2'd2;

    // One region slot as it sits in the region RAM.
    typedef struct packed {
        logic [31:0] file_length;
        logic [31:0] file_start;
        logic [2:0]  file_access;
        logic        shared;
        logic [2:0]  prot;
        logic [38:0] length;
        logic [37:0] base;
    } t_entry;

endpackage

// ----- rtl/mrfc_ram.sv -----
// Generic single-port-write, registered-read RAM.
module mrfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mrfc_alu.sv -----
// Shared add/subtract unit with a less-than compare on its result.
module mrfc_alu #(
    parameter int W = 40
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_c,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_carry,
    output logic         o_lt
);

    logic [W:0] sum_full;

    // For a subtraction the carry out is set when no borrow occurred.
    assign sum_full = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (W+1)'(i_sub);
    assign o_sum    = sum_full[W-1:0];
    assign o_carry  = sum_full[W];
    assign o_lt     = (o_sum < i_c);

endmodule

// ----- rtl/mapped_region_fault_checker.sv -----
// Top level of the mapped region fault checker.
//
// The block holds a table of mapped regions and answers page fault checks.
// Input beats arrive on the s_axis channel; s_axis_tuser carries the
// operation (0 writes one region slot, 1 checks a fault). Every input beat
// produces exactly one result beat on the m_axis channel.
// A region write goes from acceptance straight to the done state.
// A fault check scans the region RAM one slot per cycle through the shared
// add/compare unit, which also serves the later file offset steps.
// Addresses at or above the limit skip the scan and go straight to done.
// Only one item is in work at a time: s_axis_tready is high while the
// sequencer is idle. The result sits in an output register, so a new beat
// can be accepted while the previous result still waits for m_axis_tready.
// If the receiver stalls, a finished result is held until the register
// frees up, and the block accepts nothing more until then.
// Reset clears every slot's valid bit, the sequencer and the output valid;
// the slot contents themselves are not cleared and need no sweep.
module mapped_region_fault_checker
    import mrfc_pkg::*;
#(
    parameter int REGION_COUNT       = REGION_COUNT_DEF,
    parameter int ADDRESS_LIMIT_BITS = ADDRESS_LIMIT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index, entry_used, region_base, region_length, region_prot,
    // region_shared, file_access, file_start, file_length, fault_addr,
    // fault_kind
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, hit_index, page_flags, page_addr, needs_file_read,
    // read_offset, read_bytes
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int VA_W  = ADDRESS_LIMIT_BITS;
    // Wide enough for the address minus a base and for file offset sums.
    localparam int UW    = ((ADDRESS_LIMIT_BITS > 39) ? ADDRESS_LIMIT_BITS : 39) + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(REGION_COUNT - 1);
    localparam logic [UW-1:0]    PAGE_MASK = UW'(PAGE_BYTES - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_CHECK = 6'b000100,
        S_FILE1 = 6'b001000,
        S_FILE2 = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Input fields.
    logic [3:0]  s_entry_index;
    logic        s_entry_used;
    t_entry      s_entry;
    logic [63:0] s_fault_addr;
    logic [1:0]  s_fault_kind;

    assign s_entry_index       = s_axis_tdata[3:0];
    assign s_entry_used        = s_axis_tdata[4];
    assign s_entry.base        = s_axis_tdata[42:5];
    assign s_entry.length      = s_axis_tdata[81:43];
    assign s_entry.prot        = s_axis_tdata[84:82];
    assign s_entry.shared      = s_axis_tdata[85];
    assign s_entry.file_access = s_axis_tdata[88:86];
    assign s_entry.file_start  = s_axis_tdata[120:89];
    assign s_entry.file_length = s_axis_tdata[152:121];
    assign s_fault_addr        = s_axis_tdata[216:153];
    assign s_fault_kind        = s_axis_tdata[218:217];

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [REGION_COUNT-1:0] r_valid;
    logic [VA_W-1:0]   r_va;
    logic [1:0]        r_kind;
    t_entry            r_ent;
    logic [UW-1:0]     r_diff;
    logic [31:0]       r_rem;
    logic              r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic [1:0]              r_res_status;
    logic [3:0]              r_res_hit;
    logic [3:0]              r_res_flags;
    logic [37:0]             r_res_paddr;
    logic                    r_res_need;
    logic [39:0]             r_res_roff;
    logic [READ_BYTES_W-1:0] r_res_bytes;

    logic             s_acc;
    logic             addr_over;
    logic [IDX_W+3:0] idx_ext;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_in_range;
    logic             ram_we;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_entry;
    logic [$bits(t_entry)-1:0] rd_data;

    logic [UW-1:0] alu_a, alu_b, alu_c, alu_sum;
    logic          alu_sub, alu_carry, alu_lt;

    logic             hit_now;
    logic [IDX_W+3:0] cnt_ext;
    logic [UW-1:0]    page_delta;
    logic [UW-1:0]    va_ext;
    logic             perm_fail;
    logic             refuse;
    logic             file_go;
    logic             out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // Any address bit at or above the limit makes the fault refused.
    assign addr_over = (s_fault_addr[63:ADDRESS_LIMIT_BITS] != '0);

    assign idx_ext     = {{IDX_W{1'b0}}, s_entry_index};
    assign wr_addr     = idx_ext[IDX_W-1:0];
    assign wr_in_range = ({3'b000, s_entry_index} < 7'(REGION_COUNT));
    assign ram_we      = s_acc && (s_axis_tuser == OP_LOAD) && wr_in_range;

    // The RAM answers in the cycle after the address; slot 0 is requested on
    // acceptance and the scan walks ahead of r_cnt by one slot.
    assign rd_addr  = (r_state == S_SCAN) ? r_cnt + 1'b1 : '0;
    assign rd_entry = t_entry'(rd_data);

    mrfc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (REGION_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (s_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign page_delta = r_diff & ~PAGE_MASK;
    assign va_ext     = UW'(r_va);

    // Operand selection for the shared unit in each step.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_c   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_SCAN: begin
                alu_a   = va_ext;
                alu_b   = UW'(rd_entry.base);
                alu_c   = UW'(rd_entry.length);
                alu_sub = 1'b1;
            end
            S_FILE1: begin
                alu_a   = UW'(r_ent.file_length);
                alu_b   = page_delta;
                alu_sub = 1'b1;
            end
            S_FILE2: begin
                alu_a   = UW'(r_ent.file_start);
                alu_b   = page_delta;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    mrfc_alu #(
        .W (UW)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_c     (alu_c),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry),
        .o_lt    (alu_lt)
    );

    // A slot covers the address when base <= address and the distance is
    // below the length, which also makes a zero-length region never match.
    assign hit_now = r_valid[r_cnt] && alu_carry && alu_lt;
    assign cnt_ext = {4'b0000, r_cnt};

    always_comb begin
        perm_fail = ((r_kind == KIND_FETCH) && !r_ent.prot[2]) ||
                    ((r_kind == KIND_LOAD)  && !r_ent.prot[0]) ||
                    ((r_kind == KIND_STORE) && !r_ent.prot[1]);
        refuse    = perm_fail ||
                    (r_ent.file_access[0] && !r_ent.file_access[1]) ||
                    (r_ent.file_access[0] && (r_kind == KIND_STORE) &&
                     r_ent.shared && !r_ent.file_access[2]);
        file_go   = !refuse && r_ent.file_access[0];
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_cnt = '0;
                    if ((s_axis_tuser == OP_LOAD) || addr_over) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit_now) begin
                    n_state = S_CHECK;
                end else if (r_cnt == LAST_SLOT) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CHECK: begin
                n_state = file_go ? S_FILE1 : S_DONE;
            end
            S_FILE1: begin
                // The page lies inside the file data only if the remainder
                // is positive.
                n_state = (alu_carry && (alu_sum != '0)) ? S_FILE2 : S_DONE;
            end
            S_FILE2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_valid   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (ram_we) begin
                r_valid[wr_addr] <= s_entry_used;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_va         <= s_fault_addr[VA_W-1:0];
                    r_kind       <= s_fault_kind;
                    r_res_status <= ((s_axis_tuser == OP_FAULT) && addr_over) ?
                                    ST_REFUSED : ST_OK;
                    r_res_hit    <= '0;
                    r_res_flags  <= '0;
                    r_res_paddr  <= '0;
                    r_res_need   <= 1'b0;
                    r_res_roff   <= '0;
                    r_res_bytes  <= '0;
                end
            end
            S_SCAN: begin
                if (hit_now) begin
                    r_ent     <= rd_entry;
                    r_diff    <= alu_sum;
                    r_res_hit <= cnt_ext[3:0];
                end else if (r_cnt == LAST_SLOT) begin
                    r_res_status <= ST_NO_REGION;
                end
            end
            S_CHECK: begin
                r_res_flags  <= {1'b1, r_ent.prot};
                r_res_paddr  <= va_ext[37:0] & ~38'(PAGE_BYTES - 1);
                r_res_status <= refuse ? ST_REFUSED : ST_OK;
            end
            S_FILE1: begin
                r_rem <= alu_sum[31:0];
            end
            S_FILE2: begin
                r_res_need  <= 1'b1;
                r_res_roff  <= alu_sum[39:0];
                r_res_bytes <= (r_rem > 32'(PAGE_BYTES)) ? READ_BYTES_W'(PAGE_BYTES) :
                               r_rem[READ_BYTES_W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    r_m_data <= {2'b00, r_res_bytes, r_res_roff, r_res_need,
                                 r_res_paddr, r_res_flags, r_res_hit, r_res_status};
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ----- rtl/mrfc_checker.sv -----
// Port-level assertions for the mapped region fault checker, bound to the top.
module mrfc_checker
    import mrfc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  i_s_tready,
    input logic                  i_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] i_m_tdata
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result beat changed while stalled");

    // Only one item is in work: the block is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input accepted on two consecutive cycles");

    // A missing region reports nothing but its status.
    a_no_region_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tdata[1:0] == ST_NO_REGION) |-> (i_m_tdata[101:2] == '0))
        else $error("no-region result carries data");

    // File fields are set only together with the read request, and the byte
    // count never exceeds one page.
    a_file_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[101:89] <= 13'(PAGE_BYTES)) &&
                       (i_m_tdata[48] || (i_m_tdata[101:49] == '0)))
        else $error("file read fields inconsistent");

endmodule

bind mapped_region_fault_checker mrfc_checker u_mrfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

// ----- bench/mrfc_fault_checker.sv -----
// Beat layouts, result predictor and scoreboard for the mapped region fault checker bench.
package mrfc_tb_pkg;

    import mrfc_pkg::*;

    // Fault kind with no name in the block package; it passes every permission test.
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Bit positions inside region_prot and file_access.
    localparam int PROT_READ_BIT    = 0;
    localparam int PROT_WRITE_BIT   = 1;
    localparam int PROT_EXEC_BIT    = 2;
    localparam int FILE_BACKED_BIT  = 0;
    localparam int FILE_READ_BIT    = 1;
    localparam int FILE_WRITE_BIT   = 2;

    // Input beat on s_axis_tdata, declared from the top bit down.
    typedef struct packed {
        logic [4:0]  pad;
        logic [1:0]  fault_kind;
        logic [63:0] fault_addr;
        logic [31:0] file_length;
        logic [31:0] file_start;
        logic [2:0]  file_access;
        logic        region_shared;
        logic [2:0]  region_prot;
        logic [38:0] region_length;
        logic [37:0] region_base;
        logic        entry_used;
        logic [3:0]  entry_index;
    } t_request_beat;

    // Result beat on m_axis_tdata, declared from the top bit down.
    typedef struct packed {
        logic [1:0]  pad;
        logic [12:0] read_bytes;
        logic [39:0] read_offset;
        logic        needs_file_read;
        logic [37:0] page_addr;
        logic [3:0]  page_flags;
        logic [3:0]  hit_index;
        logic [1:0]  status;
    } t_result_beat;

endpackage

module mrfc_fault_checker
    import mrfc_pkg::*;
    import mrfc_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_op,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_file_reads,
    output int                    o_refusals,
    output int                    o_misses
);

    t_entry       region_slots [REGION_COUNT_DEF];
    logic         region_live  [REGION_COUNT_DEF];
    t_result_beat awaited_results [$];
    t_result_beat want;
    t_result_beat got;
    int           mismatches;
    int           file_reads;
    int           refusals;
    int           misses;

    // Updates the region table for a load beat and works out the result of any beat.
    function automatic t_result_beat resolve_fault(input logic op, input t_request_beat req);
        t_result_beat res;
        t_entry       e;
        logic [63:0]  va;
        logic [63:0]  page_delta;
        logic [63:0]  room;
        int           hit;
        bit           found;
        res = '0;
        if (op == OP_LOAD) begin
            region_live[req.entry_index]              = req.entry_used;
            region_slots[req.entry_index].base        = req.region_base;
            region_slots[req.entry_index].length      = req.region_length;
            region_slots[req.entry_index].prot        = req.region_prot;
            region_slots[req.entry_index].shared      = req.region_shared;
            region_slots[req.entry_index].file_access = req.file_access;
            region_slots[req.entry_index].file_start  = req.file_start;
            region_slots[req.entry_index].file_length = req.file_length;
            return res;
        end
        va = req.fault_addr;
        if ((va >> ADDRESS_LIMIT_BITS_DEF) != 0) begin
            res.status = ST_REFUSED;
            return res;
        end
        found = 0;
        hit   = 0;
        for (int i = 0; i < REGION_COUNT_DEF && !found; i++) begin
            if (region_live[i] && va >= region_slots[i].base &&
                    (va - region_slots[i].base) < region_slots[i].length) begin
                hit   = i;
                found = 1;
            end
        end
        if (!found) begin
            res.status = ST_NO_REGION;
            return res;
        end
        e              = region_slots[hit];
        res.hit_index  = hit[3:0];
        res.page_flags = {1'b1, e.prot};
        res.page_addr  = {va[37:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        if ((req.fault_kind == KIND_FETCH && !e.prot[PROT_EXEC_BIT]) ||
                (req.fault_kind == KIND_LOAD && !e.prot[PROT_READ_BIT]) ||
                (req.fault_kind == KIND_STORE && !e.prot[PROT_WRITE_BIT])) begin
            res.status = ST_REFUSED;
            return res;
        end
        if (!e.file_access[FILE_BACKED_BIT]) return res;
        if (!e.file_access[FILE_READ_BIT] ||
                (req.fault_kind == KIND_STORE && e.shared && !e.file_access[FILE_WRITE_BIT])) begin
            res.status = ST_REFUSED;
            return res;
        end
        page_delta = va - e.base;
        page_delta[PAGE_SHIFT-1:0] = '0;
        if (page_delta >= e.file_length) return res;
        room                = e.file_length - page_delta;
        res.needs_file_read = 1'b1;
        res.read_offset     = 40'(e.file_start + page_delta);
        res.read_bytes      = (room > PAGE_BYTES) ? 13'(PAGE_BYTES) : room[12:0];
        return res;
    endfunction

    task automatic check_field(input string label, input logic [63:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REGION_COUNT_DEF; i++) region_live[i] = 1'b0;
            awaited_results.delete();
        end else begin
            // Input first: a result can never belong to the beat taken at the same edge.
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(resolve_fault(i_in_op, t_request_beat'(i_in_data)));
            if (i_out_valid && i_out_ready) begin
                got = t_result_beat'(i_out_data);
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat 0x%0h, nothing was expected",
                             $time, i_out_data);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("hit_index", want.hit_index, got.hit_index);
                    check_field("page_flags", want.page_flags, got.page_flags);
                    check_field("page_addr", want.page_addr, got.page_addr);
                    check_field("needs_file_read", want.needs_file_read, got.needs_file_read);
                    check_field("read_offset", want.read_offset, got.read_offset);
                    check_field("read_bytes", want.read_bytes, got.read_bytes);
                    if (want.needs_file_read) file_reads++;
                    if (want.status == ST_REFUSED) refusals++;
                    if (want.status == ST_NO_REGION) misses++;
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
        o_file_reads <= file_reads;
        o_refusals   <= refusals;
        o_misses     <= misses;
    end

endmodule

// ----- bench/tb_mapped_region_fault_checker.sv -----
// Top level of the mapped region fault checker bench: clock, reset, stimulus and verdict.
module tb_mapped_region_fault_checker;

    import mrfc_pkg::*;
    import mrfc_tb_pkg::*;

    // Full reach of the address space the block accepts.
    localparam logic [63:0] ADDR_LIMIT = 64'd1 << ADDRESS_LIMIT_BITS_DEF;
    localparam logic [63:0] ADDR_MASK  = ADDR_LIMIT - 1;
    // Cycles without any beat on either channel before the run is declared hung.
    // It lies well above the long receiver hold-off below and the time a fault check takes.
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RANDOM_ITEMS     = 930;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 30;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // entry_index .. fault_kind, lowest bit up
    logic                  s_axis_tuser;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // status .. read_bytes, lowest bit up

    int fail_count;
    int pending;
    int file_reads;
    int refusals;
    int misses;

    // Stimulus-side record of what was loaded, used only to aim fault addresses.
    logic [63:0] aim_base [16];
    logic [63:0] aim_len  [16];
    logic        aim_live [16];

    int load_beats;
    int fault_beats;
    int idle_cycles;
    bit tx_quiet;
    bit rx_quiet;
    bit rx_hold_request;
    bit rx_hold_done;

    mapped_region_fault_checker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // The scoreboard watches both channels on its own and reports back its counts.
    mrfc_fault_checker i_fault_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_file_reads (file_reads),
        .o_refusals   (refusals),
        .o_misses     (misses)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Idle gap length: mostly none or short, now and then a long one.
    // A quiet stretch suppresses gaps entirely.
    function automatic int idle_length(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Every field but the pad random, so bits that the operation ignores still toggle.
    function automatic t_request_beat noise_request();
        t_request_beat req;
        req               = '0;
        req.fault_kind    = 2'($urandom());
        req.fault_addr    = rand64();
        req.file_length   = $urandom();
        req.file_start    = $urandom();
        req.file_access   = 3'($urandom());
        req.region_shared = 1'($urandom());
        req.region_prot   = 3'($urandom());
        req.region_length = 39'(rand64());
        req.region_base   = 38'(rand64());
        req.entry_used    = 1'($urandom());
        req.entry_index   = 4'($urandom());
        return req;
    endfunction

    // Offers one beat and returns at the edge where it is taken. Valid stays high
    // into the next beat when no gap follows, so it is never dropped and raised
    // within one time step.
    task automatic send_beat(input logic op, input t_request_beat req);
        int gap;
        gap = idle_length(tx_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_LOAD) load_beats++;
        else fault_beats++;
    endtask

    task automatic send_load(input logic [3:0] idx, input logic used,
                             input logic [63:0] base, input logic [63:0] len,
                             input logic [2:0] prot, input logic shared,
                             input logic [2:0] access, input logic [31:0] fstart,
                             input logic [31:0] flen);
        t_request_beat req;
        req               = noise_request();
        req.entry_index   = idx;
        req.entry_used    = used;
        req.region_base   = base[37:0];
        req.region_length = len[38:0];
        req.region_prot   = prot;
        req.region_shared = shared;
        req.file_access   = access;
        req.file_start    = fstart;
        req.file_length   = flen;
        aim_base[idx]     = base & ADDR_MASK;
        aim_len[idx]      = len;
        aim_live[idx]     = used;
        send_beat(OP_LOAD, req);
    endtask

    task automatic send_fault(input logic [63:0] va, input logic [1:0] kind);
        t_request_beat req;
        req            = noise_request();
        req.fault_addr = va;
        req.fault_kind = kind;
        send_beat(OP_FAULT, req);
    endtask

    // One random region write: mostly small page-aligned regions near each other so
    // that faults find them, with zero lengths, huge lengths and odd bases mixed in.
    task automatic random_load();
        logic [63:0] base;
        logic [63:0] len;
        logic [31:0] flen;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            base = 64'($urandom_range(0, 511)) << PAGE_SHIFT;
            if ($urandom_range(0, 4) == 0) base += $urandom_range(0, PAGE_BYTES - 1);
        end else if (r < 85) begin
            base = $urandom_range(0, 32'hFF_FFFF);
        end else begin
            base = rand64() & ADDR_MASK;
        end
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 32'h4_0000);
        else if (r < 77) len = 0;
        else if (r < 90) len = (rand64() & ADDR_MASK) | 64'd1;
        else len = ADDR_LIMIT;
        r = $urandom_range(0, 99);
        if (r < 50) flen = $urandom_range(0, 32'h3_0000);
        else if (r < 65) flen = 0;
        else flen = $urandom();
        send_load(4'($urandom()), ($urandom_range(0, 9) != 0), base, len,
                  3'($urandom()), 1'($urandom()), 3'($urandom()), $urandom(), flen);
    endtask

    // One random fault: mostly aimed into or just past a loaded region, the rest
    // scattered over low memory, the whole space and beyond the address limit.
    task automatic random_fault();
        logic [63:0] va;
        logic [63:0] off;
        logic [1:0]  kind;
        int slot;
        int r;
        r    = $urandom_range(0, 99);
        slot = $urandom_range(0, 15);
        if (r < 70 && aim_live[slot]) begin
            if (aim_len[slot] < 64'h4000_0000) off = $urandom_range(0, 32'(aim_len[slot]) + 4096);
            else off = rand64() % aim_len[slot];
            va = aim_base[slot] + off;
        end else if (r < 85) begin
            va = $urandom_range(0, 32'h1F_FFFF);
        end else if (r < 94) begin
            va = rand64() & ADDR_MASK;
        end else begin
            va = rand64();
        end
        kind = ($urandom_range(0, 19) == 0) ? KIND_UNKNOWN : 2'($urandom_range(0, 2));
        send_fault(va, kind);
    endtask

    // Receiver: random stalls of random length, with quiet stretches, plus one
    // long hold-off on request so the output register fills and input backs up.
    initial begin
        m_axis_tready = 1'b0;
        rx_quiet      = 1'b0;
        rx_hold_done  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_request && !rx_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                rx_hold_done = 1'b1;
            end else begin
                int stall;
                stall = idle_length(rx_quiet);
                if ($urandom_range(0, 30) == 0) rx_quiet = !rx_quiet;
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: any cycle with a beat on either side restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results still awaited",
                     $time, WATCHDOG_LIMIT, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_LOAD;
        load_beats      = 0;
        fault_beats     = 0;
        tx_quiet        = 1'b0;
        rx_hold_request = 1'b0;
        for (int i = 0; i < 16; i++) begin
            aim_base[i] = '0;
            aim_len[i]  = '0;
            aim_live[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: nothing is covered, and the address limit is enforced
        // whether or not a region exists.
        send_fault(64'd0, KIND_LOAD);
        send_fault(ADDR_LIMIT, KIND_STORE);
        send_fault('1, KIND_FETCH);
        send_fault(ADDR_LIMIT - 1, KIND_LOAD);

        // The top slot maps the whole address space as anonymous memory.
        send_load(4'd15, 1'b1, 64'd0, ADDR_LIMIT, 3'b111, 1'b0, 3'b000, '1, '1);
        send_fault(ADDR_LIMIT - 1, KIND_FETCH);

        // A zero-length region in slot 0 covers nothing, so slot 15 answers.
        send_load(4'd0, 1'b1, 64'h1000, 64'd0, 3'b111, 1'b0, 3'b011, '0, '0);
        send_fault(64'h1000, KIND_LOAD);

        // Read-only shared file mapping whose data ends partway through a page.
        send_load(4'd1, 1'b1, 64'h1_0000, 64'h8000, 3'b001, 1'b1, 3'b011, '1, 32'h5800);
        send_fault(64'h1_0000, KIND_LOAD);
        send_fault(64'h1_5123, KIND_LOAD);
        send_fault(64'h1_6000, KIND_LOAD);
        send_fault(64'h1_0000, KIND_FETCH);
        send_fault(64'h1_0000, KIND_STORE);
        send_fault(64'h1_7FFF, KIND_UNKNOWN);

        // Store to a shared mapping of a file that is not writable.
        send_load(4'd2, 1'b1, 64'h2_0000, 64'h1000, 3'b011, 1'b1, 3'b011, '0, 32'h1000);
        send_fault(64'h2_0800, KIND_STORE);

        // File-backed region whose file cannot be read.
        send_load(4'd3, 1'b1, 64'h3_0000, 64'h1000, 3'b111, 1'b0, 3'b001, '0, 32'h1000);
        send_fault(64'h3_0000, KIND_LOAD);

        // Store to a shared writable file mapping, last page only partly backed.
        send_load(4'd4, 1'b1, 64'h4_0000, 64'h2000, 3'b010, 1'b1, 3'b111, '0, 32'h1800);
        send_fault(64'h4_1FFF, KIND_STORE);

        // A one-byte region at the very top of the space beats slot 15 by priority.
        send_load(4'd5, 1'b1, ADDR_LIMIT - 1, 64'd1, 3'b001, 1'b0, 3'b000, '0, '0);
        send_fault(ADDR_LIMIT - 1, KIND_LOAD);

        // Invalidating slot 1 hands its addresses back to slot 15.
        send_load(4'd1, 1'b0, 64'h1_0000, 64'h8000, 3'b001, 1'b1, 3'b011, '1, 32'h5800);
        send_fault(64'h1_0000, KIND_LOAD);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 40) == 0) tx_quiet = !tx_quiet;
            // Ask for the long hold-off and keep offering beats back to back
            // so that the input side is forced to stall.
            if (n == 400) rx_hold_request = 1'b1;
            if (n >= 400 && n < 412) tx_quiet = 1'b1;
            if ($urandom_range(0, 3) == 0) random_load();
            else random_fault();
        end
        s_axis_tvalid <= 1'b0;

        // Wait for the scoreboard to publish the last accepted beat.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d region writes and %0d fault checks under random stalls on both sides.",
                 load_beats, fault_beats);
        $display("Expected outcomes: %0d file reads, %0d refusals, %0d with no region, %0d errors.",
                 file_reads, refusals, misses, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- mapped_region_fault_checker.f -----
rtl/mrfc_pkg.sv
rtl/mrfc_ram.sv
rtl/mrfc_alu.sv
rtl/mapped_region_fault_checker.sv
rtl/mrfc_checker.sv
bench/mrfc_fault_checker.sv
bench/tb_mapped_region_fault_checker.sv
